// File: rtl/a85_pkg.sv
// ============================================================================
// a85_pkg
// Shared types, character codes and helpers for the ASCII85 stream decoder.
// ============================================================================
`default_nettype none

package a85_pkg;

    // Most results one input character can cause.
    localparam int unsigned BURST_MAX = 4;

    localparam logic [7:0] CHAR_FIRST_DIGIT = 8'h21;  // '!'
    localparam logic [7:0] CHAR_LAST_DIGIT  = 8'h75;  // 'u'
    localparam logic [7:0] CHAR_ZERO_GROUP  = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_TILDE       = 8'h7E;  // '~'
    localparam logic [7:0] CHAR_GT          = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_TAB         = 8'h09;
    localparam logic [7:0] CHAR_LF          = 8'h0A;
    localparam logic [7:0] CHAR_FF          = 8'h0C;
    localparam logic [7:0] CHAR_CR          = 8'h0D;

    localparam logic [31:0] DIGIT_BASE      = 32'd85;
    localparam logic [2:0]  GROUP_DIGITS    = 3'd5;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_END       = 3'd1,
        KIND_BADCHAR   = 3'd2,
        KIND_PREMATURE = 3'd3,
        KIND_BADTERM   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_eof;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  digit_count;
        logic [31:0] group_value;
        logic        saw_tilde;
    } dec_state_t;

    // Results of one character, entry 0 delivered first.
    typedef struct packed {
        logic                            nonempty;
        out_item_t [BURST_MAX-1:0]       ent;
    } burst_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
                   (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

    // 85^(5-n) for a partial group of n digits. Padding n digits with 84 up to
    // five gives (v + 1) * 85^(5-n) - 1, modulo 2^32.
    function automatic logic [19:0] pad_pow(input logic [2:0] n);
        case (n)
            3'd2:    pad_pow = 20'd614125;
            3'd3:    pad_pow = 20'd7225;
            3'd4:    pad_pow = 20'd85;
            default: pad_pow = 20'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/a85_decode.sv
// ============================================================================
// a85_decode
// Single-pass decode of one character against the group state: next state
// and the burst of up to four results.
// ============================================================================
`default_nettype none

module a85_decode (
    input  wire a85_pkg::in_item_t   item,
    input  wire a85_pkg::dec_state_t st,
    output a85_pkg::dec_state_t      nxt,
    output a85_pkg::burst_t          burst
);
    import a85_pkg::*;

    logic [7:0]  c;
    logic [31:0] padded;
    logic [31:0] folded;
    logic [31:0] word;
    logic [2:0]  n_bytes;
    logic        has_term;
    kind_t       term_kind;
    logic [2:0]  total;

    assign c      = item.in_char;
    assign padded = 32'((st.group_value + 32'd1) * {12'd0, pad_pow(st.digit_count)})
                    - 32'd1;
    assign folded = 32'(st.group_value * DIGIT_BASE) + {24'd0, c - CHAR_FIRST_DIGIT};

    always_comb
    begin
        nxt       = st;
        word      = '0;
        n_bytes   = 3'd0;
        has_term  = 1'b0;
        term_kind = KIND_END;
        if (st.saw_tilde)
        begin
            has_term = 1'b1;
            nxt      = '0;
            if (!item.in_eof && c == CHAR_GT)
            begin
                term_kind = KIND_END;
                if (st.digit_count >= 3'd2)
                begin
                    word    = padded;
                    n_bytes = st.digit_count - 3'd1;
                end
            end
            else
            begin
                term_kind = KIND_BADTERM;
            end
        end
        else if (item.in_eof)
        begin
            has_term  = 1'b1;
            term_kind = KIND_PREMATURE;
            nxt       = '0;
        end
        else if (is_space(c))
        begin
            nxt = st;
        end
        else if (c == CHAR_TILDE)
        begin
            nxt.saw_tilde = 1'b1;
        end
        else if (c == CHAR_ZERO_GROUP && st.digit_count == 3'd0)
        begin
            n_bytes = 3'd4;
        end
        else if (c >= CHAR_FIRST_DIGIT && c <= CHAR_LAST_DIGIT)
        begin
            if (st.digit_count + 3'd1 >= GROUP_DIGITS)
            begin
                word    = folded;
                n_bytes = 3'd4;
                nxt     = '0;
            end
            else
            begin
                nxt.digit_count = st.digit_count + 3'd1;
                nxt.group_value = folded;
            end
        end
        else
        begin
            has_term  = 1'b1;
            term_kind = KIND_BADCHAR;
            nxt       = '0;
        end
    end

    assign total = n_bytes + {2'd0, has_term};

    always_comb
    begin
        burst          = '0;
        burst.nonempty = (total != 3'd0);
        for (int i = 0; i < BURST_MAX; i++)
        begin
            if (3'(i) < n_bytes)
            begin
                burst.ent[i].out_byte = word[31-8*i -: 8];
                burst.ent[i].out_kind = KIND_DATA;
            end
            else if (has_term && 3'(i) == n_bytes)
            begin
                burst.ent[i].out_byte = 8'd0;
                burst.ent[i].out_kind = term_kind;
            end
            burst.ent[i].out_last = (3'(i) == total - 3'd1);
        end
    end

endmodule

`default_nettype wire

// File: rtl/a85_burst.sv
// ============================================================================
// a85_burst
// Result register: holds one burst and hands it out one result per cycle while res_stall is low.
// ============================================================================
`default_nettype none

module a85_burst (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire a85_pkg::burst_t  burst,
    output logic                  free,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output a85_pkg::out_item_t    res_data
);
    import a85_pkg::*;

    out_item_t [BURST_MAX-1:0]     ent_reg;
    logic                          busy_reg;
    logic                          busy_next;
    logic [$clog2(BURST_MAX)-1:0]  idx_reg;
    logic [$clog2(BURST_MAX)-1:0]  idx_next;
    logic                          drain;
    logic                          drain_last;

    assign res_valid  = busy_reg;
    assign res_data   = ent_reg[idx_reg];
    assign drain      = busy_reg && !res_stall;
    assign drain_last = drain && ent_reg[idx_reg].out_last;
    assign free       = !busy_reg || drain_last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load && burst.nonempty)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (drain_last)
        begin
            busy_next = 1'b0;
            idx_next  = '0;
        end
        else if (drain)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= burst.ent;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ascii85_stream_decoder_unit.sv
// ============================================================================
// ascii85_stream_decoder_unit
// Streaming ASCII85 decoder: characters in, decoded bytes and status out.
// ============================================================================
`default_nettype none

// One character is accepted per cycle while the input is not stalled. Each
// character is registered, decoded in a single pass against the group state
// (a 32-bit value, a digit count and a pending '~' flag) and its results,
// zero to four of them, are loaded into a result register that delivers one
// result per cycle while res_stall is low. Characters that give no result
// (whitespace, the first four digits of a group, '~') pass at the full rate
// of one per cycle unless a previous burst still drains. The results of a
// character leave the result port one by one; one more character may wait
// in the input register meanwhile. Each character goes through the input
// register and then the result register on its way to the port. After an end
// or error result the decoder restarts cleanly on the next character.
module ascii85_stream_decoder_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_valid,
    output logic                   char_stall,
    input  wire a85_pkg::in_item_t char_data,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output a85_pkg::out_item_t     res_data
);
    import a85_pkg::*;

    // Input register
    in_item_t   item_reg;
    logic       item_valid_reg;
    logic       item_valid_next;

    // Group state
    dec_state_t state_reg;
    dec_state_t state_next;
    dec_state_t dec_next;

    burst_t     burst;
    logic       free;
    logic       advance;
    logic       take;

    // Advance the held request into the result register once it can take it;
    // hold the input while the previous burst still drains.
    assign advance    = item_valid_reg && free;
    assign char_stall = item_valid_reg && !free;
    assign take       = char_valid && !char_stall;

    a85_decode u_decode (
        .item  (item_reg),
        .st    (state_reg),
        .nxt   (dec_next),
        .burst (burst)
    );

    a85_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .burst     (burst),
        .free      (free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    // Commit the group state only when the request moves on.
    assign state_next = advance ? dec_next : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            state_reg      <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= char_data;
        end
    end

`ifndef NO_ASSERTIONS
    // A group never holds five digits: the fifth digit always flushes it.
    a_digit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digit_count <= 3'd4)
        else $error("digit count out of range");

    // End and error results are always the last of their burst.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.out_kind != KIND_DATA |-> res_data.out_last)
        else $error("status result not marked last");

    // Input stalls only while a request is held.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> item_valid_reg && res_valid)
        else $error("input stalled without a held request");

    // A pending '~' leaves the group untouched until the next character.
    a_tilde_keeps_group: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.saw_tilde) |-> $stable(state_reg.group_value))
        else $error("group changed on tilde");
`endif

endmodule

`default_nettype wire

// File: sim/ascii85_stream_decoder_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// ascii85_stream_decoder_unit_test
// Self-checking bench for the streaming ASCII85 decoder. A shadow decoder
// in the bench predicts every result of each accepted character request. The
// result port is checked in order against those predictions. Directed
// requests cover the corner cases. Random streams of well-formed groups,
// terminators, whitespace and noise follow, with idle gaps on both sides.
// ============================================================================

module ascii85_stream_decoder_unit_test;

    import a85_pkg::*;

    localparam int RANDOM_ITEMS  = 330;
    localparam int WATCHDOG_MAX  = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES   = 8;     // settle time once nothing is awaited

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_stall;
    in_item_t   char_data = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    out_item_t  res_data;

    // Shadow decoder state; the block resets to the same values.
    logic [2:0]  dec_digits = 3'd0;
    logic [31:0] dec_value  = 32'd0;
    logic        dec_tilde  = 1'b0;

    // Results of the request being decoded, before they are queued.
    out_item_t   burst_buf [BURST_MAX];
    int          burst_len;

    out_item_t   awaited_results [$];
    out_item_t   want_result;

    int          fail_count    = 0;
    int          requests_sent = 0;
    int          idle_cycles   = 0;
    bit          no_idle       = 1'b0;

    ascii85_stream_decoder_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow decoder
    // ------------------------------------------------------------------------

    function automatic void stage_result(input logic [7:0] b, input kind_t k);
        burst_buf[burst_len].out_byte = b;
        burst_buf[burst_len].out_kind = k;
        burst_buf[burst_len].out_last = 1'b0;
        burst_len++;
    endfunction

    // Stage the n high bytes of a group value, most significant first.
    function automatic void stage_bytes(input logic [31:0] v, input int n);
        int i;
        for (i = 0; i < n; i++)
            stage_result(v[31 - 8 * i -: 8], KIND_DATA);
    endfunction

    function automatic void clear_group();
        dec_digits = 3'd0;
        dec_value  = 32'd0;
        dec_tilde  = 1'b0;
    endfunction

    // Advance the shadow state by one accepted request and queue its results.
    function automatic void decode_char(input in_item_t item);
        logic [31:0] v;
        logic [7:0]  c;
        int          i;
        c = item.in_char;
        burst_len = 0;
        if (dec_tilde)
        begin
            // A waiting '~' takes the next character as is, whitespace too.
            if (!item.in_eof && c == CHAR_GT)
            begin
                if (dec_digits >= 3'd2)
                begin
                    // Pad the partial group with the top digit up to five.
                    v = dec_value;
                    for (i = int'(dec_digits); i < 5; i++)
                        v = v * 32'd85 + 32'd84;
                    stage_bytes(v, int'(dec_digits) - 1);
                end
                stage_result(8'h00, KIND_END);
            end
            else
                stage_result(8'h00, KIND_BADTERM);
            clear_group();
        end
        else if (item.in_eof)
        begin
            stage_result(8'h00, KIND_PREMATURE);
            clear_group();
        end
        else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
                 c == CHAR_FF || c == CHAR_CR)
        begin
            // Skip whitespace.
        end
        else if (c == CHAR_TILDE)
            dec_tilde = 1'b1;
        else if (c == CHAR_ZERO_GROUP && dec_digits == 3'd0)
            stage_bytes(32'd0, 4);
        else if (c >= CHAR_FIRST_DIGIT && c <= CHAR_LAST_DIGIT)
        begin
            dec_value  = dec_value * 32'd85 + {24'd0, c - CHAR_FIRST_DIGIT};
            dec_digits = dec_digits + 3'd1;
            if (dec_digits == 3'd5)
            begin
                stage_bytes(dec_value, 4);
                dec_digits = 3'd0;
                dec_value  = 32'd0;
            end
        end
        else
        begin
            // Covers 'z' inside a group as well as any other stray byte.
            stage_result(8'h00, KIND_BADCHAR);
            clear_group();
        end
        if (burst_len > 0)
            burst_buf[burst_len - 1].out_last = 1'b1;
        for (i = 0; i < burst_len; i++)
            awaited_results.push_back(burst_buf[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall, in-order check, watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
        res_stall <= !no_idle && ($urandom_range(0, 99) < 9);

    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got byte %02h kind %0d last %0d",
                         $time, res_data.out_byte, res_data.out_kind, res_data.out_last);
                fail_count++;
            end
            else
            begin
                want_result = awaited_results.pop_front();
                if (res_data.out_byte !== want_result.out_byte ||
                    res_data.out_kind !== want_result.out_kind ||
                    res_data.out_last !== want_result.out_last)
                begin
                    $display("%0t: mismatch, expected byte %02h kind %0d last %0d, got byte %02h kind %0d last %0d",
                             $time, want_result.out_byte, want_result.out_kind,
                             want_result.out_last, res_data.out_byte,
                             res_data.out_kind, res_data.out_last);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles without any handshake; a hung block ends the run here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_stall === 1'b0) ||
                (res_valid === 1'b1 && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: watchdog expired with %0d results awaited",
                         $time, awaited_results.size());
                $display("FAIL ascii85_stream_decoder_unit");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request, hold it until accepted, then predict its results.
    // Valid stays high into the next request unless an idle gap is drawn.
    task automatic send_request(input logic [7:0] c, input logic eof);
        in_item_t item;
        item.in_char = c;
        item.in_eof  = eof;
        if (!no_idle && $urandom_range(0, 99) < 9)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= item;
        @(posedge clk);
        while (char_stall !== 1'b0)
            @(posedge clk);
        decode_char(item);
        requests_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_request(s[i], 1'b0);
    endtask

    // Drop valid and hold off until every awaited result has arrived.
    task automatic hold_until_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_space();
        case ($urandom_range(0, 4))
            0:       send_request(CHAR_SPACE, 1'b0);
            1:       send_request(CHAR_TAB, 1'b0);
            2:       send_request(CHAR_LF, 1'b0);
            3:       send_request(CHAR_FF, 1'b0);
            default: send_request(CHAR_CR, 1'b0);
        endcase
    endtask

    // One digit, sometimes preceded by whitespace; lean on the top digit so
    // that overflowing groups turn up often.
    task automatic send_digit();
        if ($urandom_range(0, 9) == 0)
            send_space();
        if ($urandom_range(0, 7) == 0)
            send_request(CHAR_LAST_DIGIT, 1'b0);
        else
            send_request(CHAR_FIRST_DIGIT + 8'($urandom_range(0, 84)), 1'b0);
    endtask

    // Full groups and 'z' groups, a partial group, then a terminator that is
    // mostly well formed.
    task automatic send_stream();
        int groups;
        int g;
        int d;
        groups = $urandom_range(0, 4);
        for (g = 0; g < groups; g++)
        begin
            if ($urandom_range(0, 6) == 0)
                send_request(CHAR_ZERO_GROUP, 1'b0);
            else
                for (d = 0; d < 5; d++)
                    send_digit();
        end
        for (d = $urandom_range(0, 4); d > 0; d--)
            send_digit();
        case ($urandom_range(0, 19))
            16:
            begin
                send_request(CHAR_TILDE, 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            17: send_request(8'($urandom_range(0, 255)), 1'b1);
            18:
            begin
                send_request(CHAR_TILDE, 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end
            19: send_request(8'($urandom_range(0, 255)), 1'b0);
            default: send_text("~>");
        endcase
    endtask

    task automatic send_noise();
        int n;
        for (n = $urandom_range(1, 4); n > 0; n--)
        begin
            if ($urandom_range(0, 7) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b1);
            else
                send_request(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Smallest and largest digits (the latter overflows), then a zero group.
    task automatic test_full_groups();
        send_text("!!!!!");
        send_text("uuuuu");
        send_request(CHAR_ZERO_GROUP, 1'b0);
    endtask

    // Two-digit partial group with whitespace inside, then a lone leftover
    // digit that is dropped at the terminator.
    task automatic test_partial_groups();
        send_text("u\t!~>");
        send_text("5~>");
    endtask

    // 'z' inside a group, bytes outside the alphabet, whitespace after '~',
    // end of input alone and end of input after '~'.
    task automatic test_bad_input();
        send_text("!z");
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_text("~ ");
        send_request(8'hFF, 1'b1);
        send_request(CHAR_TILDE, 1'b0);
        send_request(8'h00, 1'b1);
    endtask

    // Mostly well-formed streams with random content, some noise. Drop
    // idling for a long stretch and hold off once until drained.
    task automatic test_random_streams();
        int  start;
        int  n;
        bit  drained;
        start   = requests_sent;
        drained = 1'b0;
        while (requests_sent - start < RANDOM_ITEMS)
        begin
            n = requests_sent - start;
            no_idle = (n >= 120 && n < 220);
            if (!drained && n >= 240)
            begin
                hold_until_drained();
                drained = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
                send_stream();
            else
                send_noise();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_groups();
        test_partial_groups();
        test_bad_input();
        test_random_streams();

        // Let every awaited result arrive, then allow for stray extras.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("PASS ascii85_stream_decoder_unit");
        else
            $display("FAIL ascii85_stream_decoder_unit");
        $finish;
    end

endmodule
